// ----- hw/rtl/tcsc_pkg.sv -----
// Shared types and constants for the tetrahedral carbon strain check.
// No dependencies.
`timescale 1ns / 1ps

package tcsc_pkg;

  localparam int unsigned CoordW   = 24;
  localparam int unsigned DiffW    = 25;
  localparam int unsigned UnitW    = 17;
  localparam int unsigned ThrW     = 16;
  localparam int unsigned InDataW  = 152;
  localparam int unsigned OutDataW = 8;

  localparam logic [6:0]  CarbonZ   = 7'd6;
  localparam logic [2:0]  CountSat  = 3'd5;
  localparam logic [2:0]  CountFull = 3'd4;
  localparam logic [16:0] UnitOne   = 17'd32768;

  typedef struct packed {
    logic                    carbon;
    logic                    present;
    logic                    atom_end;
    logic                    mol_end;
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] dz;
  } item_t;

  typedef enum logic [3:0] {
    B_IDLE, B_SUMSQ, B_SQRT, B_DIVSET, B_DIV, B_FIN, B_VPREP, B_VMUL, B_VCMP, B_END
  } bstate_t;

endpackage

// ----- hw/rtl/tcsc_front.sv -----
// Front end: accepts stream items, forms bond differences, classifies them
// and holds them in a two-entry queue. Depends on tcsc_pkg.
`timescale 1ns / 1ps

module tcsc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tcsc_pkg::InDataW-1:0]    in_data,
  input  logic [1:0]                      in_user,
  input  logic                            in_last,
  output logic                            q_valid,
  input  logic                            q_ready,
  output tcsc_pkg::item_t                 q_item
);
  import tcsc_pkg::*;

  item_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  item_t      it;
  logic       push;
  logic       pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = mem[rptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    it.carbon   = (in_data[6:0] == CarbonZ);
    it.present  = in_user[0];
    it.mol_end  = in_last;
    it.atom_end = in_user[1] || in_last;
    it.dx = $signed({in_data[102], in_data[102:79]})  - $signed({in_data[30], in_data[30:7]});
    it.dy = $signed({in_data[126], in_data[126:103]}) - $signed({in_data[54], in_data[54:31]});
    it.dz = $signed({in_data[150], in_data[150:127]}) - $signed({in_data[78], in_data[78:55]});
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= it;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule

// ----- hw/rtl/tcsc_back.sv -----
// Back end: normalizes bond vectors with an iterative square root and divider,
// tests tetrahedron volume with one shared multiplier, emits the flag.
// Depends on tcsc_pkg.
`timescale 1ns / 1ps

module tcsc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  tcsc_pkg::item_t               q_item,
  input  logic [tcsc_pkg::ThrW-1:0]     threshold,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_strained
);
  import tcsc_pkg::*;

  bstate_t state;
  bstate_t state_next;

  item_t                   it;
  logic [2:0]              cnt;
  logic [1:0]              widx;
  logic [1:0]              comp;
  logic [4:0]              step;
  logic [49:0]             sacc;
  logic [62:0]             v;
  logic [62:0]             r;
  logic [62:0]             bitr;
  logic [45:0]             rem;
  logic [46:0]             dv;
  logic [15:0]             q;
  logic signed [UnitW-1:0] uv [4][3];
  logic signed [17:0]      av [3];
  logic signed [17:0]      bv [3];
  logic signed [17:0]      cv [3];
  logic signed [36:0]      xr [3];
  logic signed [55:0]      acc;
  logic                    flag;

  logic signed [DiffW-1:0] dsel;
  logic [23:0]             absd;
  logic [47:0]             sq;
  logic [62:0]             rsum;
  logic [30:0]             m;
  logic [45:0]             num;
  logic                    zero_or_sat;
  logic                    qbit;
  logic [16:0]             qfin;
  logic [16:0]             qclamp;
  logic signed [UnitW-1:0] uval;
  logic signed [36:0]      ma;
  logic signed [17:0]      mb;
  logic signed [54:0]      prod;
  logic [55:0]             mag;
  logic [47:0]             limit;
  logic                    out_free;

  always_comb begin
    case (comp)
      2'd0:    dsel = it.dx;
      2'd1:    dsel = it.dy;
      default: dsel = it.dz;
    endcase
  end

  always_comb begin
    logic signed [DiffW-1:0] sd;
    case (step[1:0])
      2'd0:    sd = it.dx;
      2'd1:    sd = it.dy;
      default: sd = it.dz;
    endcase
    sq = (sd[DiffW-1] ? 24'(-sd) : sd[23:0]) * (sd[DiffW-1] ? 24'(-sd) : sd[23:0]);
  end

  assign absd        = dsel[DiffW-1] ? 24'(-dsel) : dsel[23:0];
  assign rsum        = r + bitr;
  assign m           = r[30:0];
  assign num         = 46'({absd, 21'b0}) + 46'(m[30:1]);
  assign zero_or_sat = (m == 31'd0) || ({2'b0, num} >= {m, 17'b0});
  assign qbit        = ({1'b0, rem} >= dv);
  assign qfin        = (state == B_DIV) ? {q, qbit} : ((m == 31'd0) ? 17'd0 : UnitOne);
  assign qclamp      = (qfin > UnitOne) ? UnitOne : qfin;
  assign uval        = dsel[DiffW-1] ? -$signed(qclamp) : $signed(qclamp);
  assign out_free    = !out_valid || out_ready;

  always_comb begin
    case (step[3:0])
      4'd0:    begin ma = 37'(av[1]); mb = bv[2]; end
      4'd1:    begin ma = 37'(av[2]); mb = bv[1]; end
      4'd2:    begin ma = 37'(av[2]); mb = bv[0]; end
      4'd3:    begin ma = 37'(av[0]); mb = bv[2]; end
      4'd4:    begin ma = 37'(av[0]); mb = bv[1]; end
      4'd5:    begin ma = 37'(av[1]); mb = bv[0]; end
      4'd6:    begin ma = xr[0]; mb = cv[0]; end
      4'd7:    begin ma = xr[1]; mb = cv[1]; end
      default: begin ma = xr[2]; mb = cv[2]; end
    endcase
  end

  assign prod  = ma * mb;
  assign mag   = acc[55] ? 56'(-acc) : 56'(acc);
  assign limit = {19'(threshold) * 19'd6, 29'b0};

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    unique case (state)
      B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_item.carbon && q_item.present && cnt < CountFull) state_next = B_SUMSQ;
          else state_next = B_FIN;
        end
      end
      B_SUMSQ:  if (step == 5'd2) state_next = B_SQRT;
      B_SQRT:   if (step == 5'd31) state_next = B_DIVSET;
      B_DIVSET: begin
        if (!zero_or_sat) state_next = B_DIV;
        else if (comp == 2'd2) state_next = B_FIN;
      end
      B_DIV: begin
        if (step == 5'd16) state_next = (comp == 2'd2) ? B_FIN : B_DIVSET;
      end
      B_FIN: begin
        if (it.atom_end && it.carbon && cnt == CountFull) state_next = B_VPREP;
        else state_next = B_END;
      end
      B_VPREP:  state_next = B_VMUL;
      B_VMUL:   if (step == 5'd8) state_next = B_VCMP;
      B_VCMP:   state_next = B_END;
      B_END:    if (!it.mol_end || out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        it   <= q_item;
        step <= 5'd0;
        comp <= 2'd0;
        sacc <= 50'd0;
        widx <= cnt[1:0];
      end
      B_SUMSQ: begin
        sacc <= sacc + 50'(sq);
        step <= (step == 5'd2) ? 5'd0 : step + 5'd1;
        v    <= {1'b0, sacc + 50'(sq), 12'b0};
        r    <= 63'd0;
        bitr <= 63'd1 << 62;
      end
      B_SQRT: begin
        if (v >= rsum) begin
          v <= v - rsum;
          r <= (r >> 1) + bitr;
        end else begin
          r <= r >> 1;
        end
        bitr <= bitr >> 2;
        step <= step + 5'd1;
      end
      B_DIVSET: begin
        rem  <= num;
        dv   <= {m, 16'b0};
        q    <= 16'd0;
        step <= 5'd0;
        if (zero_or_sat) begin
          uv[widx][comp] <= uval;
          comp <= comp + 2'd1;
        end
      end
      B_DIV: begin
        if (qbit) rem <= rem - dv[45:0];
        q    <= {q[14:0], qbit};
        dv   <= dv >> 1;
        step <= step + 5'd1;
        if (step == 5'd16) begin
          uv[widx][comp] <= uval;
          comp <= comp + 2'd1;
        end
      end
      B_FIN: step <= 5'd0;
      B_VPREP: begin
        for (int i = 0; i < 3; i++) begin
          av[i] <= 18'(uv[1][i]) - 18'(uv[0][i]);
          bv[i] <= 18'(uv[2][i]) - 18'(uv[0][i]);
          cv[i] <= 18'(uv[3][i]) - 18'(uv[0][i]);
        end
      end
      B_VMUL: begin
        step <= step + 5'd1;
        if (step < 5'd6) begin
          if (!step[0]) acc <= 56'(prod);
          else xr[step[2:1]] <= 37'(acc - 56'(prod));
        end else if (step == 5'd6) begin
          acc <= 56'(prod);
        end else begin
          acc <= acc + 56'(prod);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= 3'd0;
      flag         <= 1'b0;
      out_valid    <= 1'b0;
      out_strained <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == B_IDLE && q_valid && q_item.carbon && q_item.present && cnt != CountSat) begin
        cnt <= cnt + 3'd1;
      end
      if (state == B_VCMP && mag < 56'(limit)) flag <= 1'b1;
      if (state == B_END && (!it.mol_end || out_free)) begin
        if (it.atom_end) cnt <= 3'd0;
        if (it.mol_end) begin
          out_valid    <= 1'b1;
          out_strained <= flag;
          flag         <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/tetrahedral_carbon_strain_check_top.sv -----
// In the back end each item passes through the idle, finish and end states, plus
// any wait for the output transfer; a present neighbor of a carbon among its
// first four also goes through summing its squared differences, a bit-serial
// square root and up to three bit-serial divisions, and the end of a carbon with
// four neighbors adds the triple product on one shared multiplier. A two-entry
// queue lets the input run ahead of that work.
// Top level: threshold register, front end and back end.
// Depends on tcsc_pkg, tcsc_front, tcsc_back.
`timescale 1ns / 1ps

module tetrahedral_carbon_strain_check_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // atomic_number, origin_x, origin_y, origin_z, neighbor_x, neighbor_y, neighbor_z
  input  logic [tcsc_pkg::InDataW-1:0]  s_axis_tdata,
  // neighbor_present, atom_last
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // strained
  output logic [tcsc_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcsc_pkg::ThrW-1:0]     cfg_data
);
  import tcsc_pkg::*;

  logic [ThrW-1:0] threshold;
  logic            q_valid;
  logic            q_ready;
  item_t           q_item;
  logic            strained;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {7'b0, strained};

  always_ff @(posedge clk) begin
    if (rst) threshold <= 16'd22610;
    else if (cfg_valid) threshold <= cfg_data;
  end

  tcsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .in_user  (s_axis_tuser),
    .in_last  (s_axis_tlast),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  tcsc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .threshold    (threshold),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_strained (strained)
  );

endmodule
